[rtl/abs_pkg.sv]
`default_nettype none
package abs_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int INDEX_BITS_DEF = 16;

  localparam int SCORE_BITS   = 24;
  localparam int LEN_OUT_BITS = 17;
  localparam int CHAR_BITS    = 8;
  localparam int COMP_BITS    = 8;
  localparam int CFG_IDX_BITS = 3;
  localparam int PEN_BITS     = 4;

  localparam logic [CHAR_BITS-1:0] GAP_CHAR = 8'd45;

  localparam int BEST_START     = -100;
  localparam int GAP_CLOSE      = -8;
  localparam int MISMATCH_SCORE = -4;
  localparam int VERDICT_BASE   = 20;
  localparam int PENALTY_CAP    = 10;
  localparam int COMPETE_FREE   = 5;
  localparam int MIN_BEST_LEN   = 10;
  localparam int DIST_CHECK     = 20;
  localparam int DIST_STEP      = 10;

  localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_ANCHOR_END    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_ANCHOR_START = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_ANCHOR_COORD  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_ANCHOR_COORD = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_READ_LENGTH   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_READ_LENGTH  = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_COMPETING          = 3'd6;

endpackage
`default_nettype wire

[rtl/abs_col.sv]
`default_nettype none
module abs_col #(
  parameter int COORD_BITS = abs_pkg::COORD_BITS_DEF,
  parameter int INDEX_BITS = abs_pkg::INDEX_BITS_DEF
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    in_valid,
  output logic                                   in_ready,
  input  wire  [abs_pkg::CHAR_BITS-1:0]          in_top_char,
  input  wire  [abs_pkg::CHAR_BITS-1:0]          in_bottom_char,
  input  wire                                    in_left_repeat,
  input  wire                                    in_right_repeat,
  input  wire  [COORD_BITS-1:0]                  in_left_coord_here,
  input  wire  [COORD_BITS-1:0]                  in_right_coord_here,
  input  wire                                    in_last_column,
  input  wire  [INDEX_BITS-1:0]                  left_anchor_end,
  input  wire  [INDEX_BITS-1:0]                  right_anchor_start,
  input  wire  [COORD_BITS-1:0]                  left_anchor_coord,
  input  wire  [COORD_BITS-1:0]                  right_anchor_coord,
  input  wire  [COORD_BITS:0]                    dist_init,
  output logic                                   fin_valid,
  input  wire                                    fin_ready,
  output logic signed [abs_pkg::SCORE_BITS-1:0]  fin_score,
  output logic [INDEX_BITS:0]                    fin_length,
  output logic [COORD_BITS:0]                    fin_dist
);

  localparam int CNT_W   = INDEX_BITS + 1;
  localparam int DIST_W  = COORD_BITS + 1;
  localparam int SCORE_W = abs_pkg::SCORE_BITS;
  localparam int RS_W    = SCORE_W + 3;
  localparam int DW      = (COORD_BITS > CNT_W ? COORD_BITS : CNT_W) + 3;
  localparam logic signed [RS_W-1:0] S_MAX = RS_W'((2 ** (SCORE_W - 1)) - 1);
  localparam logic signed [RS_W-1:0] S_MIN = -S_MAX - RS_W'(1);

  // column word register
  logic                          col_v_r;
  logic [abs_pkg::CHAR_BITS-1:0] top_r, bot_r;
  logic                          lrep_r, rrep_r, last_r;
  logic [COORD_BITS-1:0]         lch_r, rch_r;

  // alignment state
  logic [CNT_W-1:0]          tc_r, tc_nxt, bc_r, bc_nxt;
  logic                      gap_open_r, gap_open_nxt, gap_row_r, gap_row_nxt;
  logic signed [SCORE_W-1:0] rs_r, rs_nxt, best_r, best_nxt;
  logic [CNT_W-1:0]          rl_r, rl_nxt, bestl_r, bestl_nxt;
  logic [DIST_W-1:0]         md_r, md_nxt;
  logic                      busy_r, busy_nxt;

  logic                      fin_v_r, fin_v_nxt;
  logic signed [SCORE_W-1:0] fin_score_r;
  logic [CNT_W-1:0]          fin_len_r;
  logic [DIST_W-1:0]         fin_dist_r;

  logic col_adv;

  // column datapath
  logic                      gap0, gap1, eq, close_gap, still_open, go_new, gr_new;
  logic signed [3:0]         match;
  logic signed [4:0]         gs;
  logic signed [RS_W-1:0]    base, base_v, rs_sum, rs_sat, rs_fin;
  logic                      rst_run;
  logic [CNT_W-1:0]          rl0, rl1, rl_fin;
  logic                      take_best;
  logic [DIST_W-1:0]         md_cur, md_new;
  logic signed [DW-1:0]      lc, rc, diff;

  assign col_adv  = col_v_r && (!last_r || !fin_v_r || fin_ready);
  assign in_ready = !col_v_r || col_adv;

  always_comb begin
    gap0       = (top_r == abs_pkg::GAP_CHAR);
    gap1       = (bot_r == abs_pkg::GAP_CHAR);
    eq         = (top_r == bot_r);
    close_gap  = gap_open_r && !(gap_row_r ? gap1 : gap0);
    still_open = gap_open_r && !close_gap;
    if (still_open) begin
      go_new = 1'b1;
      gr_new = gap_row_r;
    end else begin
      go_new = gap0 || gap1;
      gr_new = gap1;
    end
    gs = close_gap ? 5'(abs_pkg::GAP_CLOSE) : 5'sd0;

    if (go_new) begin
      match = 4'sd0;
    end else if (eq) begin
      match = ((tc_r != '0) && (bc_r != '0) && (lrep_r || rrep_r)) ? 4'sd0 : 4'sd1;
    end else begin
      match = 4'(abs_pkg::MISMATCH_SCORE);
    end

    base    = RS_W'(rs_r) + RS_W'(gs);
    rst_run = (base < 0) && (bc_r <= CNT_W'(right_anchor_start));
    base_v  = rst_run ? '0 : base;
    rs_sum  = base_v + RS_W'(match);
    if (rs_sum > S_MAX) begin
      rs_sat = S_MAX;
    end else if (rs_sum < S_MIN) begin
      rs_sat = S_MIN;
    end else begin
      rs_sat = rs_sum;
    end
    rl0 = rst_run ? '0 : rl_r;
    rl1 = (rl0 == '1) ? rl0 : rl0 + CNT_W'(1);
    if ((rs_sat < 0) && (bc_r < CNT_W'(right_anchor_start))) begin
      rs_fin = '0;
      rl_fin = '0;
    end else begin
      rs_fin = rs_sat;
      rl_fin = rl1;
    end

    take_best = (tc_r >= CNT_W'(left_anchor_end)) && !go_new &&
                ((SCORE_W'(rs_fin) == best_r) ? (rl_fin > bestl_r)
                                               : ($signed(SCORE_W'(rs_fin)) > best_r));

    md_cur = busy_r ? md_r : dist_init;
    if (tc_r <= CNT_W'(left_anchor_end)) begin
      lc = signed'(DW'(lch_r));
    end else begin
      lc = signed'(DW'(left_anchor_coord)) + signed'(DW'(tc_r)) -
           signed'(DW'(left_anchor_end));
    end
    if (CNT_W'(right_anchor_start) <= bc_r) begin
      rc = signed'(DW'(rch_r));
    end else begin
      rc = signed'(DW'(right_anchor_coord)) - signed'(DW'(right_anchor_start)) +
           signed'(DW'(bc_r));
    end
    diff   = (lc > rc) ? (lc - rc) : (rc - lc);
    md_new = md_cur;
    if ((md_cur >= DIST_W'(abs_pkg::DIST_CHECK)) && eq && (DW'(diff) < DW'(md_cur))) begin
      md_new = diff[DIST_W-1:0];
    end
  end

  always_comb begin
    tc_nxt       = tc_r;
    bc_nxt       = bc_r;
    gap_open_nxt = gap_open_r;
    gap_row_nxt  = gap_row_r;
    rs_nxt       = rs_r;
    rl_nxt       = rl_r;
    best_nxt     = best_r;
    bestl_nxt    = bestl_r;
    md_nxt       = md_r;
    busy_nxt     = busy_r;
    if (col_adv) begin
      if (last_r) begin
        tc_nxt       = '0;
        bc_nxt       = '0;
        gap_open_nxt = 1'b0;
        gap_row_nxt  = 1'b0;
        rs_nxt       = '0;
        rl_nxt       = '0;
        best_nxt     = SCORE_W'(abs_pkg::BEST_START);
        bestl_nxt    = '0;
        busy_nxt     = 1'b0;
      end else begin
        tc_nxt       = (gap0 || tc_r == '1) ? tc_r : tc_r + CNT_W'(1);
        bc_nxt       = (gap1 || bc_r == '1) ? bc_r : bc_r + CNT_W'(1);
        gap_open_nxt = go_new;
        gap_row_nxt  = gr_new;
        rs_nxt       = SCORE_W'(rs_fin);
        rl_nxt       = rl_fin;
        if (take_best) begin
          best_nxt  = SCORE_W'(rs_fin);
          bestl_nxt = rl_fin;
        end
        busy_nxt     = 1'b1;
      end
      md_nxt = md_new;
    end
  end

  assign fin_v_nxt = (fin_v_r && !fin_ready) || (col_adv && last_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_v_r    <= 1'b0;
      fin_v_r    <= 1'b0;
      tc_r       <= '0;
      bc_r       <= '0;
      gap_open_r <= 1'b0;
      gap_row_r  <= 1'b0;
      rs_r       <= '0;
      rl_r       <= '0;
      best_r     <= SCORE_W'(abs_pkg::BEST_START);
      bestl_r    <= '0;
      busy_r     <= 1'b0;
    end else begin
      col_v_r    <= in_valid || (col_v_r && !col_adv);
      fin_v_r    <= fin_v_nxt;
      tc_r       <= tc_nxt;
      bc_r       <= bc_nxt;
      gap_open_r <= gap_open_nxt;
      gap_row_r  <= gap_row_nxt;
      rs_r       <= rs_nxt;
      rl_r       <= rl_nxt;
      best_r     <= best_nxt;
      bestl_r    <= bestl_nxt;
      busy_r     <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    md_r <= md_nxt;
    if (in_valid && in_ready) begin
      top_r  <= in_top_char;
      bot_r  <= in_bottom_char;
      lrep_r <= in_left_repeat;
      rrep_r <= in_right_repeat;
      lch_r  <= in_left_coord_here;
      rch_r  <= in_right_coord_here;
      last_r <= in_last_column;
    end
    if (col_adv && last_r) begin
      fin_score_r <= take_best ? SCORE_W'(rs_fin) : best_r;
      fin_len_r   <= take_best ? rl_fin : bestl_r;
      fin_dist_r  <= md_new;
    end
  end

  assign fin_valid  = fin_v_r;
  assign fin_score  = fin_score_r;
  assign fin_length = fin_len_r;
  assign fin_dist   = fin_dist_r;

endmodule
`default_nettype wire

[rtl/abs_verdict.sv]
`default_nettype none
module abs_verdict #(
  parameter int COORD_BITS = abs_pkg::COORD_BITS_DEF,
  parameter int INDEX_BITS = abs_pkg::INDEX_BITS_DEF
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    fin_valid,
  output logic                                   fin_ready,
  input  wire signed [abs_pkg::SCORE_BITS-1:0]   fin_score,
  input  wire  [INDEX_BITS:0]                    fin_length,
  input  wire  [COORD_BITS:0]                    fin_dist,
  input  wire  [abs_pkg::COMP_BITS-1:0]          competing,
  output logic                                   out_valid,
  input  wire                                    out_ready,
  output logic                                   out_is_bridge,
  output logic signed [abs_pkg::SCORE_BITS-1:0]  out_best_score,
  output logic [abs_pkg::LEN_OUT_BITS-1:0]       out_best_length
);

  localparam int CNT_W   = INDEX_BITS + 1;
  localparam int DIST_W  = COORD_BITS + 1;
  localparam int SCORE_W = abs_pkg::SCORE_BITS;
  localparam int PW      = abs_pkg::PEN_BITS;
  localparam int VW      = (SCORE_W > CNT_W ? SCORE_W : CNT_W) + 2;

  logic                             out_v_r;
  logic                             bridge_r;
  logic signed [SCORE_W-1:0]        score_r;
  logic [abs_pkg::LEN_OUT_BITS-1:0] len_r;

  logic [PW-1:0]         cp, mp;
  logic signed [VW-1:0]  total, need;
  logic                  bridge;

  assign fin_ready = !out_v_r || out_ready;

  always_comb begin
    if (competing <= abs_pkg::COMP_BITS'(abs_pkg::COMPETE_FREE)) begin
      cp = '0;
    end else if (competing >=
                 abs_pkg::COMP_BITS'(abs_pkg::COMPETE_FREE + abs_pkg::PENALTY_CAP)) begin
      cp = PW'(abs_pkg::PENALTY_CAP);
    end else begin
      cp = PW'(competing - abs_pkg::COMP_BITS'(abs_pkg::COMPETE_FREE));
    end
    // distance penalty: one step per 10 above 10, capped
    mp = '0;
    for (int k = 1; k <= abs_pkg::PENALTY_CAP; k++) begin
      mp = mp + PW'(fin_dist >= DIST_W'(abs_pkg::DIST_STEP * (k + 1)));
    end
    total  = VW'(fin_score) + signed'(VW'(fin_length));
    need   = VW'(abs_pkg::VERDICT_BASE) + signed'(VW'(cp)) + signed'(VW'(mp));
    bridge = (fin_score > 0) && (fin_length >= CNT_W'(abs_pkg::MIN_BEST_LEN)) &&
             (total >= need);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= (fin_valid && fin_ready) || (out_v_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && fin_ready) begin
      bridge_r <= bridge;
      score_r  <= fin_score;
      len_r    <= abs_pkg::LEN_OUT_BITS'(fin_length);
    end
  end

  assign out_valid       = out_v_r;
  assign out_is_bridge   = bridge_r;
  assign out_best_score  = score_r;
  assign out_best_length = len_r;

endmodule
`default_nettype wire

[rtl/alignment_bridge_scorer_core.sv]
// A last column's result passes the column, fin and verdict registers to out_*.
// Throughput: one column word per cycle; result words are held in an output register
// and a verdict register, so input keeps flowing while up to two results wait; a
// third last column then holds the input until a result word is taken.
// Reset: synchronous active-low rst_n clears handshake state, alignment state and
// all configuration registers; no clearing pass is needed.
`default_nettype none
module alignment_bridge_scorer_core #(
  parameter int COORD_BITS = abs_pkg::COORD_BITS_DEF,
  parameter int INDEX_BITS = abs_pkg::INDEX_BITS_DEF
) (
  input  wire                                        clk,
  input  wire                                        rst_n,
  input  wire                                        cfg_we,
  input  wire  [abs_pkg::CFG_IDX_BITS-1:0]           cfg_index,
  input  wire  [(COORD_BITS > INDEX_BITS ? COORD_BITS : INDEX_BITS)-1:0] cfg_wdata,
  input  wire                                        in_valid,
  output logic                                       in_ready,
  input  wire  [abs_pkg::CHAR_BITS-1:0]              in_top_char,
  input  wire  [abs_pkg::CHAR_BITS-1:0]              in_bottom_char,
  input  wire                                        in_left_repeat,
  input  wire                                        in_right_repeat,
  input  wire  [COORD_BITS-1:0]                      in_left_coord_here,
  input  wire  [COORD_BITS-1:0]                      in_right_coord_here,
  input  wire                                        in_last_column,
  output logic                                       out_valid,
  input  wire                                        out_ready,
  output logic                                       out_is_bridge,
  output logic signed [abs_pkg::SCORE_BITS-1:0]      out_best_score,
  output logic [abs_pkg::LEN_OUT_BITS-1:0]           out_best_length
);

  localparam int DIST_W = COORD_BITS + 1;
  localparam int CNT_W  = INDEX_BITS + 1;
  localparam int SW     = (COORD_BITS > CNT_W ? COORD_BITS : CNT_W) + 2;

  logic [INDEX_BITS-1:0]         lae_r, ras_r, lrl_r, rrl_r;
  logic [COORD_BITS-1:0]         lac_r, rac_r;
  logic [abs_pkg::COMP_BITS-1:0] comp_r;
  logic [DIST_W-1:0]             dist_init_r;

  logic [COORD_BITS-1:0]     coord_gap;
  logic [SW-1:0]             dist_sum;
  logic [DIST_W-1:0]         dist_init_nxt;

  logic                      fin_valid, fin_ready;
  logic signed [abs_pkg::SCORE_BITS-1:0] fin_score;
  logic [CNT_W-1:0]          fin_length;
  logic [DIST_W-1:0]         fin_dist;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lae_r  <= '0;
      ras_r  <= '0;
      lac_r  <= '0;
      rac_r  <= '0;
      lrl_r  <= '0;
      rrl_r  <= '0;
      comp_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        abs_pkg::REG_LEFT_ANCHOR_END:    lae_r  <= cfg_wdata[INDEX_BITS-1:0];
        abs_pkg::REG_RIGHT_ANCHOR_START: ras_r  <= cfg_wdata[INDEX_BITS-1:0];
        abs_pkg::REG_LEFT_ANCHOR_COORD:  lac_r  <= cfg_wdata[COORD_BITS-1:0];
        abs_pkg::REG_RIGHT_ANCHOR_COORD: rac_r  <= cfg_wdata[COORD_BITS-1:0];
        abs_pkg::REG_LEFT_READ_LENGTH:   lrl_r  <= cfg_wdata[INDEX_BITS-1:0];
        abs_pkg::REG_RIGHT_READ_LENGTH:  rrl_r  <= cfg_wdata[INDEX_BITS-1:0];
        abs_pkg::REG_COMPETING:          comp_r <= cfg_wdata[abs_pkg::COMP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // starting distance: anchor gap plus both read lengths, saturated
  always_comb begin
    coord_gap = (lac_r > rac_r) ? (lac_r - rac_r) : (rac_r - lac_r);
    dist_sum  = SW'(coord_gap) + SW'(lrl_r) + SW'(rrl_r);
    dist_init_nxt = (dist_sum > SW'({DIST_W{1'b1}})) ? '1 : DIST_W'(dist_sum);
  end

  always_ff @(posedge clk) begin
    dist_init_r <= dist_init_nxt;
  end

  abs_col #(
    .COORD_BITS (COORD_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_col (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_top_char         (in_top_char),
    .in_bottom_char      (in_bottom_char),
    .in_left_repeat      (in_left_repeat),
    .in_right_repeat     (in_right_repeat),
    .in_left_coord_here  (in_left_coord_here),
    .in_right_coord_here (in_right_coord_here),
    .in_last_column      (in_last_column),
    .left_anchor_end     (lae_r),
    .right_anchor_start  (ras_r),
    .left_anchor_coord   (lac_r),
    .right_anchor_coord  (rac_r),
    .dist_init           (dist_init_r),
    .fin_valid           (fin_valid),
    .fin_ready           (fin_ready),
    .fin_score           (fin_score),
    .fin_length          (fin_length),
    .fin_dist            (fin_dist)
  );

  abs_verdict #(
    .COORD_BITS (COORD_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_verdict (
    .clk             (clk),
    .rst_n           (rst_n),
    .fin_valid       (fin_valid),
    .fin_ready       (fin_ready),
    .fin_score       (fin_score),
    .fin_length      (fin_length),
    .fin_dist        (fin_dist),
    .competing       (comp_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_is_bridge   (out_is_bridge),
    .out_best_score  (out_best_score),
    .out_best_length (out_best_length)
  );

endmodule
`default_nettype wire

[verif/bridge_verdict_checker.sv]
`timescale 1ns / 1ps
module bridge_verdict_checker
  import abs_pkg::*;
(
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  wire  [CFG_IDX_BITS-1:0]      cfg_index,
  input  wire  [COORD_BITS_DEF-1:0]    cfg_wdata,
  input  wire                          in_valid,
  input  wire                          in_ready,
  input  wire  [CHAR_BITS-1:0]         in_top_char,
  input  wire  [CHAR_BITS-1:0]         in_bottom_char,
  input  wire                          in_left_repeat,
  input  wire                          in_right_repeat,
  input  wire  [COORD_BITS_DEF-1:0]    in_left_coord_here,
  input  wire  [COORD_BITS_DEF-1:0]    in_right_coord_here,
  input  wire                          in_last_column,
  input  wire                          out_valid,
  input  wire                          out_ready,
  input  wire                          out_is_bridge,
  input  wire  [SCORE_BITS-1:0]        out_best_score,
  input  wire  [LEN_OUT_BITS-1:0]      out_best_length,
  output int                           pending,
  output int                           errors
);

  localparam longint CNT_MAX  = (64'd1 << (INDEX_BITS_DEF + 1)) - 1;
  localparam longint DIST_MAX = (64'd1 << (COORD_BITS_DEF + 1)) - 1;
  localparam longint SCORE_HI = (64'd1 << (SCORE_BITS - 1)) - 1;
  localparam longint SCORE_LO = -SCORE_HI - 1;

  typedef struct packed {
    logic                    bridge;
    logic [SCORE_BITS-1:0]   score;
    logic [LEN_OUT_BITS-1:0] length;
  } verdict_t;

  verdict_t verdict_q[$];
  int       mismatches = 0;

  longint la_end, ra_start, la_coord, ra_coord, l_len, r_len, n_compete;
  longint top_n, bot_n, run_sc, run_len, best_sc, best_len, min_dist;
  bit     gap_open, gap_row, busy;

  assign errors = mismatches;

  function automatic void clear_alignment();
    top_n    = 0;
    bot_n    = 0;
    gap_open = 1'b0;
    gap_row  = 1'b0;
    run_sc   = 0;
    run_len  = 0;
    best_sc  = BEST_START;
    best_len = 0;
    min_dist = 0;
    busy     = 1'b0;
  endfunction

  function automatic void report_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  function automatic void score_column(input logic [7:0] ch0, ch1,
                                       input logic rep_l, rep_r,
                                       input logic [23:0] crd_l, crd_r,
                                       input logic is_last);
    longint   span, gap_pen, pts, lc, rc, diff, cp, mp;
    verdict_t v;
    if (!busy) begin
      span = (la_coord > ra_coord ? la_coord - ra_coord : ra_coord - la_coord) + l_len + r_len;
      min_dist = span > DIST_MAX ? DIST_MAX : span;
      busy = 1'b1;
    end

    gap_pen = 0;
    if (gap_open && (gap_row ? ch1 : ch0) != GAP_CHAR) begin
      gap_pen  = GAP_CLOSE;
      gap_open = 1'b0;
    end
    if (!gap_open) begin
      if (ch0 == GAP_CHAR) begin
        gap_open = 1'b1;
        gap_row  = 1'b0;
      end
      if (ch1 == GAP_CHAR) begin
        gap_open = 1'b1;
        gap_row  = 1'b1;
      end
    end

    pts = gap_open ? 0 : (ch0 == ch1 ? 1 : MISMATCH_SCORE);
    if (top_n != 0 && bot_n != 0 && pts > 0 && (rep_l || rep_r)) pts = 0;

    if (run_sc + gap_pen < 0 && bot_n <= ra_start) begin
      run_sc  = 0;
      run_len = 0;
      gap_pen = 0;
    end
    run_sc = run_sc + gap_pen + pts;
    if (run_sc > SCORE_HI) run_sc = SCORE_HI;
    if (run_sc < SCORE_LO) run_sc = SCORE_LO;
    if (run_len < CNT_MAX) run_len++;
    if (run_sc < 0 && bot_n < ra_start) begin
      run_sc  = 0;
      run_len = 0;
    end

    if (top_n >= la_end && !gap_open &&
        (run_sc == best_sc ? run_len > best_len : run_sc > best_sc)) begin
      best_sc  = run_sc;
      best_len = run_len;
    end

    if (min_dist >= DIST_CHECK && ch0 == ch1) begin
      lc = (top_n <= la_end) ? longint'(crd_l) : la_coord + (top_n - la_end);
      rc = (ra_start <= bot_n) ? longint'(crd_r) : ra_coord - (ra_start - bot_n);
      diff = lc > rc ? lc - rc : rc - lc;
      if (diff < min_dist) min_dist = diff;
    end

    if (ch0 != GAP_CHAR && top_n < CNT_MAX) top_n++;
    if (ch1 != GAP_CHAR && bot_n < CNT_MAX) bot_n++;

    if (is_last) begin
      cp = n_compete - COMPETE_FREE;
      if (cp < 0) cp = 0;
      if (cp > PENALTY_CAP) cp = PENALTY_CAP;
      mp = (min_dist - DIST_STEP) / DIST_STEP;
      if (mp < 0) mp = 0;
      if (mp > PENALTY_CAP) mp = PENALTY_CAP;
      v.bridge = best_sc > 0 && best_len >= MIN_BEST_LEN &&
                 best_sc + best_len >= VERDICT_BASE + cp + mp;
      v.score  = best_sc[SCORE_BITS-1:0];
      v.length = best_len[LEN_OUT_BITS-1:0];
      verdict_q = {verdict_q, v};
      clear_alignment();
    end
  endfunction

  always @(posedge clk) begin
    verdict_t v;
    if (!rst_n) begin
      la_end    = 0;
      ra_start  = 0;
      la_coord  = 0;
      ra_coord  = 0;
      l_len     = 0;
      r_len     = 0;
      n_compete = 0;
      clear_alignment();
      verdict_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LEFT_ANCHOR_END:    la_end    = cfg_wdata[INDEX_BITS_DEF-1:0];
          REG_RIGHT_ANCHOR_START: ra_start  = cfg_wdata[INDEX_BITS_DEF-1:0];
          REG_LEFT_ANCHOR_COORD:  la_coord  = cfg_wdata;
          REG_RIGHT_ANCHOR_COORD: ra_coord  = cfg_wdata;
          REG_LEFT_READ_LENGTH:   l_len     = cfg_wdata[INDEX_BITS_DEF-1:0];
          REG_RIGHT_READ_LENGTH:  r_len     = cfg_wdata[INDEX_BITS_DEF-1:0];
          REG_COMPETING:          n_compete = cfg_wdata[COMP_BITS-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          report_failure($sformatf("unexpected result word: bridge=%0d score=%0d length=%0d",
                                   out_is_bridge, $signed(out_best_score), out_best_length));
        end else begin
          v = verdict_q.pop_front();
          if (out_is_bridge !== v.bridge || out_best_score !== v.score ||
              out_best_length !== v.length)
            report_failure($sformatf(
              "mismatch: expected bridge=%0d score=%0d length=%0d, got bridge=%0d score=%0d length=%0d",
              v.bridge, $signed(v.score), v.length,
              out_is_bridge, $signed(out_best_score), out_best_length));
        end
      end

      if (in_valid && in_ready)
        score_column(in_top_char, in_bottom_char, in_left_repeat, in_right_repeat,
                     in_left_coord_here, in_right_coord_here, in_last_column);
    end
    pending <= verdict_q.size();
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import abs_pkg::*;

  localparam int LIMIT = 200000;

  typedef struct {
    logic [CHAR_BITS-1:0]      ch_top;
    logic [CHAR_BITS-1:0]      ch_bot;
    logic                      rep_l;
    logic                      rep_r;
    logic [COORD_BITS_DEF-1:0] coord_l;
    logic [COORD_BITS_DEF-1:0] coord_r;
    logic                      is_last;
  } column_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
  logic [COORD_BITS_DEF-1:0] cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [CHAR_BITS-1:0]      in_top_char = '0;
  logic [CHAR_BITS-1:0]      in_bottom_char = '0;
  logic                      in_left_repeat = 1'b0;
  logic                      in_right_repeat = 1'b0;
  logic [COORD_BITS_DEF-1:0] in_left_coord_here = '0;
  logic [COORD_BITS_DEF-1:0] in_right_coord_here = '0;
  logic                      in_last_column = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      out_is_bridge;
  logic [SCORE_BITS-1:0]     out_best_score;
  logic [LEN_OUT_BITS-1:0]   out_best_length;

  int pending;
  int errors;
  int cycles = 0;
  int send_idle_pct = 34;
  int recv_idle_pct = 49;
  int sent_items = 0;
  int phase = 0;

  logic [COORD_BITS_DEF-1:0] cur_la_end, cur_ra_start, cur_lac, cur_rac;
  logic [COORD_BITS_DEF-1:0] cur_ll, cur_rl, cur_comp;
  logic [CHAR_BITS-1:0]      bases [4] = '{8'd65, 8'd67, 8'd71, 8'd84};

  alignment_bridge_scorer_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_top_char         (in_top_char),
    .in_bottom_char      (in_bottom_char),
    .in_left_repeat      (in_left_repeat),
    .in_right_repeat     (in_right_repeat),
    .in_left_coord_here  (in_left_coord_here),
    .in_right_coord_here (in_right_coord_here),
    .in_last_column      (in_last_column),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_is_bridge       (out_is_bridge),
    .out_best_score      (out_best_score),
    .out_best_length     (out_best_length)
  );

  bridge_verdict_checker u_verdict_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_top_char         (in_top_char),
    .in_bottom_char      (in_bottom_char),
    .in_left_repeat      (in_left_repeat),
    .in_right_repeat     (in_right_repeat),
    .in_left_coord_here  (in_left_coord_here),
    .in_right_coord_here (in_right_coord_here),
    .in_last_column      (in_last_column),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_is_bridge       (out_is_bridge),
    .out_best_score      (out_best_score),
    .out_best_length     (out_best_length),
    .pending             (pending),
    .errors              (errors)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAIL alignment_bridge_scorer_core");
      $finish;
    end
  end

  task automatic send_column(input column_t c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_top_char         <= c.ch_top;
    in_bottom_char      <= c.ch_bot;
    in_left_repeat      <= c.rep_l;
    in_right_repeat     <= c.rep_r;
    in_left_coord_here  <= c.coord_l;
    in_right_coord_here <= c.coord_r;
    in_last_column      <= c.is_last;
    sent_items++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold off the sender until every verdict word is back, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [COORD_BITS_DEF-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic run_alignment();
    column_t                   c;
    int                        n, k, ti, bi, gap_side, b, pick;
    bit                        noise;
    logic [COORD_BITS_DEF-1:0] lb, rb;
    noise = ($urandom_range(0, 99) < 15);
    n = noise ? $urandom_range(1, 6) : $urandom_range(8, 26);
    lb = cur_lac - cur_la_end;
    rb = cur_rac - cur_ra_start;
    ti = 0;
    bi = 0;
    gap_side = 2;
    for (k = 0; k < n; k++) begin
      b = $urandom_range(0, 3);
      c.ch_top = bases[b];
      c.ch_bot = bases[b];
      if (noise) begin
        c.ch_top = ($urandom_range(0, 3) == 0) ? GAP_CHAR : 8'($urandom);
        c.ch_bot = ($urandom_range(0, 3) == 0) ? GAP_CHAR : 8'($urandom);
      end else if (gap_side != 2 && $urandom_range(0, 99) < 50) begin
        if (gap_side == 0) c.ch_top = GAP_CHAR;
        else c.ch_bot = GAP_CHAR;
      end else begin
        gap_side = 2;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          c.ch_bot = bases[(b + $urandom_range(1, 3)) % 4];
        end else if (pick < 16) begin
          c.ch_top = GAP_CHAR;
          gap_side = 0;
        end else if (pick < 22) begin
          c.ch_bot = GAP_CHAR;
          gap_side = 1;
        end else if (pick < 25) begin
          c.ch_top = GAP_CHAR;
          c.ch_bot = GAP_CHAR;
        end
      end
      if (noise || $urandom_range(0, 99) < 8) begin
        c.coord_l = 24'($urandom);
        c.coord_r = 24'($urandom);
        c.rep_l   = 1'($urandom_range(0, 1));
        c.rep_r   = 1'($urandom_range(0, 1));
      end else begin
        c.coord_l = lb + 24'(ti) + 24'($urandom_range(0, 2));
        c.coord_r = rb + 24'(bi) + 24'($urandom_range(0, 2));
        c.rep_l   = ($urandom_range(0, 99) < 20);
        c.rep_r   = ($urandom_range(0, 99) < 20);
      end
      c.is_last = (k == n - 1);
      if (c.ch_top != GAP_CHAR) ti++;
      if (c.ch_bot != GAP_CHAR) bi++;
      send_column(c);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: gap open and close on either row, both rows gapped, repeats
    send_column(column_t'{8'd0, 8'd0, 1'b0, 1'b0, 24'd0, 24'd0, 1'b0});
    send_column(column_t'{8'd255, 8'd255, 1'b1, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 1'b0});
    send_column(column_t'{GAP_CHAR, 8'd65, 1'b1, 1'b0, 24'd5, 24'd7, 1'b0});
    send_column(column_t'{GAP_CHAR, GAP_CHAR, 1'b0, 1'b1, 24'd6, 24'd7, 1'b0});
    send_column(column_t'{8'd67, 8'd67, 1'b0, 1'b0, 24'd7, 24'd8, 1'b0});
    send_column(column_t'{GAP_CHAR, GAP_CHAR, 1'b0, 1'b0, 24'd8, 24'd9, 1'b0});
    send_column(column_t'{8'd65, 8'd71, 1'b1, 1'b1, 24'd9, 24'd10, 1'b0});
    send_column(column_t'{8'd71, GAP_CHAR, 1'b0, 1'b0, 24'h800000, 24'h7FFFFF, 1'b0});
    send_column(column_t'{8'd84, 8'd84, 1'b0, 1'b0, 24'd11, 24'd11, 1'b1});
    for (int i = 0; i < 14; i++)
      send_column(column_t'{8'd65, 8'd65, 1'b0, 1'b0, 24'(i), 24'(i), i == 13});

    while (sent_items < 420) begin
      drain();
      case (phase % 5)
        0: begin
          cur_la_end   = '0;
          cur_ra_start = '0;
          cur_lac      = '0;
          cur_rac      = '0;
          cur_ll       = '0;
          cur_rl       = '0;
          cur_comp     = '0;
        end
        1: begin
          cur_la_end   = 24'hFFFF;
          cur_ra_start = 24'hFFFF;
          cur_lac      = 24'hFFFFFF;
          cur_rac      = 24'hFFFFFF;
          cur_ll       = 24'hFFFF;
          cur_rl       = 24'hFFFF;
          cur_comp     = 24'hFF;
        end
        4: begin
          cur_la_end   = 24'($urandom_range(0, 65535));
          cur_ra_start = 24'($urandom_range(0, 65535));
          cur_lac      = 24'($urandom);
          cur_rac      = 24'($urandom);
          cur_ll       = 24'($urandom_range(0, 65535));
          cur_rl       = 24'($urandom_range(0, 65535));
          cur_comp     = 24'($urandom_range(0, 255));
        end
        default: begin
          cur_la_end   = 24'($urandom_range(0, 8));
          cur_ra_start = 24'($urandom_range(0, 16));
          cur_lac      = 24'($urandom_range(1000, 24'hF00000));
          cur_rac      = cur_lac - cur_la_end + cur_ra_start + 24'($urandom_range(0, 15));
          cur_ll       = 24'($urandom_range(0, 30));
          cur_rl       = 24'($urandom_range(0, 30));
          cur_comp     = (phase % 5 == 3) ? 24'($urandom_range(200, 255))
                                          : 24'($urandom_range(0, 20));
        end
      endcase
      write_reg(REG_LEFT_ANCHOR_END, cur_la_end);
      write_reg(REG_RIGHT_ANCHOR_START, cur_ra_start);
      write_reg(REG_LEFT_ANCHOR_COORD, cur_lac);
      write_reg(REG_RIGHT_ANCHOR_COORD, cur_rac);
      write_reg(REG_LEFT_READ_LENGTH, cur_ll);
      write_reg(REG_RIGHT_READ_LENGTH, cur_rl);
      write_reg(REG_COMPETING, cur_comp);
      cfg_we <= 1'b0;
      repeat (4) begin
        if (sent_items < 180) begin
          send_idle_pct <= 34;
          recv_idle_pct <= 49;
        end else if (sent_items < 340) begin
          send_idle_pct <= 49;
          recv_idle_pct <= 34;
        end else begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
        run_alignment();
      end
      phase++;
    end

    drain();
    #1;
    if (errors == 0) begin
      $display("PASS alignment_bridge_scorer_core");
    end else begin
      $display("FAIL alignment_bridge_scorer_core");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/abs_pkg.sv
rtl/abs_col.sv
rtl/abs_verdict.sv
rtl/alignment_bridge_scorer_core.sv
verif/bridge_verdict_checker.sv
verif/testbench.sv
